// ===== src/gaussian_weight_interp_lut_assert.svh =====
// Assertion macros used by the checker file of the kernel weight block.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef GAUSSIAN_WEIGHT_INTERP_LUT_ASSERT_SVH
`define GAUSSIAN_WEIGHT_INTERP_LUT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GWIL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gwil assertion failed");

// next-cycle implication, disabled during reset
`define GWIL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gwil assertion failed");

`endif

// ===== src/gwil_pkg.sv =====
// Package for the Gaussian kernel weight lookup: field widths, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package gwil_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int DIST_W   = 24;  // Q7.16 signed distance
  localparam int SCALE_W  = 32;  // Q16.16 index scale
  localparam int STEPS_W  = 10;
  localparam int INDEX_W  = 10;  // table entry index field
  localparam int SAMPLE_W = 16;  // Q0.16 samples and weights
  localparam int FRAC_W   = 16;
  localparam int POS_INT_LSB = 32;  // integer part of the Q23.32 position

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_SCALE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_IN_USE = 1'd1;

  localparam logic [SCALE_W-1:0] INDEX_SCALE_RST  = 32'd65536;
  localparam logic [STEPS_W-1:0] STEPS_IN_USE_RST = 10'd992;

  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

endpackage

// ===== src/gwil_ifs.sv =====
// Valid/ready channel interfaces of the kernel weight block: request,
// result and configuration write. Depends on gwil_pkg.
`timescale 1ns / 1ps

interface gwil_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [gwil_pkg::DIST_W-1:0]  distance;
  logic [gwil_pkg::INDEX_W-1:0]        entry_index;
  logic [gwil_pkg::SAMPLE_W-1:0]       entry_value;

  modport source (output valid, opcode, distance, entry_index, entry_value, input ready);
  modport sink   (input valid, opcode, distance, entry_index, entry_value, output ready);
endinterface

interface gwil_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gwil_pkg::SAMPLE_W-1:0] weight;
  logic                          beyond_radius;

  modport source (output valid, weight, beyond_radius, input ready);
  modport sink   (input valid, weight, beyond_radius, output ready);
endinterface

interface gwil_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gwil_pkg::CFG_IDX_W-1:0]  index;
  logic [gwil_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gwil_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gwil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/gaussian_weight_interp_lut.sv =====
// Gaussian kernel weight by linear interpolation in a loaded sample table.
// Depends on gwil_pkg, gwil_ifs and gwil_ram.
//
//   channel | dir | payload                                      | role
//   req     | in  | opcode, distance, entry_index, entry_value   | evaluate / table write
//   rsp     | out | weight, beyond_radius                        | one per evaluate
//   cfg     | in  | index, data                                  | register write
//
// One item per cycle sustained while the result channel is ready; a result passes
// through six register stages (magnitude, multiply, slot reduction, table read, blend, round).
// Table writes take effect at the table read stage, in request order.
// rst clears valid bits and the configuration registers; the table holds nothing until loaded.
// Each stage holds under back-pressure and empty stages still fill.
`timescale 1ns / 1ps

module gaussian_weight_interp_lut #(
  parameter int TABLE_DEPTH = gwil_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  gwil_req_if.sink   req,
  gwil_rsp_if.source rsp,
  gwil_cfg_if.sink   cfg
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int IW     = gwil_pkg::INDEX_W;
  localparam int POS_W  = gwil_pkg::DIST_W + gwil_pkg::SCALE_W;
  localparam int IDX_W  = gwil_pkg::DIST_W - 1;   // integer part, |d| <= 2^23
  localparam int SW     = gwil_pkg::SAMPLE_W;
  localparam int FW     = gwil_pkg::FRAC_W;

  // slot = x mod TABLE_DEPTH for x < 2^IW, by reciprocal multiply
  localparam int SLOT_SH = IW + ADDR_W;
  localparam int RECIP_W = IW + 2;
  localparam int QP_W    = IW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SLOT_SH) + TABLE_DEPTH - 1) / TABLE_DEPTH);

  localparam int BL_W = 2 * SW + 2;
  localparam logic signed [BL_W-1:0] ROUND_HALF = BL_W'(1 << (FW - 1));

  // configuration registers
  logic [gwil_pkg::SCALE_W-1:0] index_scale;
  logic [gwil_pkg::STEPS_W-1:0] steps_in_use;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_scale  <= gwil_pkg::INDEX_SCALE_RST;
      steps_in_use <= gwil_pkg::STEPS_IN_USE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        gwil_pkg::REG_INDEX_SCALE:  index_scale  <= cfg.data;
        gwil_pkg::REG_STEPS_IN_USE: steps_in_use <= cfg.data[gwil_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when the one after it is empty or moving
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || rsp.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  // stage 1: magnitude (negating the most negative code gives 2^23 unsigned)
  logic                         op1;
  logic [gwil_pkg::DIST_W-1:0]  mag1;
  logic [IW-1:0]                ei1;
  logic [SW-1:0]                ev1;
  logic [gwil_pkg::DIST_W-1:0]  mag_in;

  assign mag_in = req.distance[gwil_pkg::DIST_W-1] ? (~req.distance + 1'b1) : req.distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1  <= req.opcode;
      mag1 <= mag_in;
      ei1  <= req.entry_index;
      ev1  <= req.entry_value;
    end
  end

  // stage 2: position = magnitude * scale, Q23.32
  logic             op2;
  logic [IDX_W-1:0] idx2;
  logic [FW-1:0]    frac2;
  logic [IW-1:0]    ei2;
  logic [SW-1:0]    ev2;
  logic [POS_W-1:0] pos;

  assign pos = POS_W'(mag1) * POS_W'(index_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2   <= op1;
      idx2  <= pos[gwil_pkg::POS_INT_LSB +: IDX_W];
      frac2 <= pos[gwil_pkg::POS_INT_LSB-1 -: FW];
      ei2   <= ei1;
      ev2   <= ev1;
    end
  end

  // stage 3: radius test, slot quotients for the two addresses
  logic            op3, beyond3;
  logic [FW-1:0]   frac3;
  logic [SW-1:0]   ev3;
  logic [IW-1:0]   xa3, xb3, qa3, qb3;
  logic [IW-1:0]   xa, xb;
  logic [QP_W-1:0] qa_prod, qb_prod;
  logic            beyond_in;

  // below the radius the index is at most 1022, so ten bits hold it and its successor
  assign beyond_in = idx2 >= IDX_W'(steps_in_use);
  assign xa = (op2 == gwil_pkg::OP_WRITE) ? ei2 : idx2[IW-1:0];
  assign xb = idx2[IW-1:0] + IW'(frac2 != '0);
  assign qa_prod = QP_W'(xa) * QP_W'(RECIP);
  assign qb_prod = QP_W'(xb) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      op3     <= op2;
      beyond3 <= beyond_in;
      frac3   <= frac2;
      ev3     <= ev2;
      xa3     <= xa;
      xb3     <= xb;
      qa3     <= IW'(qa_prod >> SLOT_SH);
      qb3     <= IW'(qb_prod >> SLOT_SH);
    end
  end

  // stage 4: table access; writes and reads happen here, in item order
  logic [IW-1:0]     ra, rb;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              tbl_we;
  logic [SW-1:0]     tbl_a, tbl_b;
  logic              beyond4;
  logic [FW-1:0]     frac4;

  assign ra = xa3 - IW'(qa3 * TABLE_DEPTH);
  assign rb = xb3 - IW'(qb3 * TABLE_DEPTH);
  assign addr_a = ADDR_W'(ra);
  assign addr_b = ADDR_W'(rb);
  assign tbl_we = v3 && (op3 == gwil_pkg::OP_WRITE) && en4;

  gwil_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (addr_a),
    .wdata   (ev3),
    .re      (en4),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (tbl_a),
    .rdata_b (tbl_b)
  );

  // write items end at the table
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3 && (op3 == gwil_pkg::OP_EVALUATE);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      beyond4 <= beyond3;
      frac4   <= frac3;
    end
  end

  // stage 5: frac * (b - a)
  logic signed [SW:0]     diff;
  logic signed [BL_W-1:0] prod5;
  logic [SW-1:0]          a5;
  logic                   beyond5;

  assign diff = $signed({1'b0, tbl_b}) - $signed({1'b0, tbl_a});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      prod5   <= BL_W'($signed({1'b0, frac4}) * diff);
      a5      <= tbl_a;
      beyond5 <= beyond4;
    end
  end

  // stage 6: a*2^16 + frac*(b-a) + half, which is never negative
  logic signed [BL_W-1:0] sum;
  logic [SW-1:0]          weight6;
  logic                   beyond6;

  assign sum = $signed({2'b00, a5, {FW{1'b0}}}) + prod5 + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      weight6 <= beyond5 ? '0 : sum[FW +: SW];
      beyond6 <= beyond5;
    end
  end

  assign rsp.valid         = v6;
  assign rsp.weight        = weight6;
  assign rsp.beyond_radius = beyond6;

endmodule

// ===== src/gwil_checker.sv =====
// Port-level checks for the kernel weight block, bound to the top level.
// Depends on gaussian_weight_interp_lut_assert.svh and gwil_pkg.
`timescale 1ns / 1ps
`include "gaussian_weight_interp_lut_assert.svh"

module gwil_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gwil_pkg::SAMPLE_W-1:0] weight,
  input logic                          beyond_radius
);

  // a result past the radius carries no weight
  `GWIL_ASSERT_IMP(a_beyond_zero, out_valid && beyond_radius, weight == '0)

  // with the output register empty nothing can hold the pipeline back
  `GWIL_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)

  // no result straight out of reset
  `GWIL_ASSERT_IMP(a_quiet_after_reset, $past(rst), !out_valid)

  // a stalled result holds
  `GWIL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(weight) && $stable(beyond_radius))

endmodule

bind gaussian_weight_interp_lut gwil_checker u_gwil_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .weight        (rsp.weight),
  .beyond_radius (rsp.beyond_radius)
);

// ===== sim/gaussian_weight_interp_lut_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Gaussian kernel weight lookup: queued request driver,
// result monitor with an in-bench weight predictor, random idling on both channels.
// Depends on gwil_pkg, gwil_ifs and gaussian_weight_interp_lut.

module gaussian_weight_interp_lut_test;

  localparam int DIST_W      = gwil_pkg::DIST_W;
  localparam int SCALE_W     = gwil_pkg::SCALE_W;
  localparam int STEPS_W     = gwil_pkg::STEPS_W;
  localparam int INDEX_W     = gwil_pkg::INDEX_W;
  localparam int SAMPLE_W    = gwil_pkg::SAMPLE_W;
  localparam int FRAC_W      = gwil_pkg::FRAC_W;
  localparam int POS_INT_LSB = gwil_pkg::POS_INT_LSB;
  localparam int CFG_IDX_W   = gwil_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = gwil_pkg::CFG_DATA_W;

  localparam int DEPTH         = gwil_pkg::TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [63:0] MAG_MAX = 64'h80_0000;

  typedef struct {
    logic                     opcode;
    logic signed [DIST_W-1:0] distance;
    logic [INDEX_W-1:0]       entry_index;
    logic [SAMPLE_W-1:0]      entry_value;
  } lut_req_t;

  typedef struct {
    logic [SAMPLE_W-1:0] weight;
    logic                beyond;
  } weight_res_t;

  logic clk;
  logic rst;

  gwil_req_if req_ch ();
  gwil_rsp_if rsp_ch ();
  gwil_cfg_if cfg_ch ();

  gaussian_weight_interp_lut #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  lut_req_t            pending_reqs[$];
  weight_res_t         weight_due[$];
  logic [SAMPLE_W-1:0] table_copy [DEPTH];
  bit                  loaded [DEPTH];    // entries already queued for writing
  logic [SCALE_W-1:0]  cur_scale;
  logic [STEPS_W-1:0]  cur_steps;
  bit                  req_fire, rsp_fire, cfg_fire;
  bit                  stall_on;
  int                  req_gap, rsp_gap;
  int                  error_count;
  int                  queued_count;
  lut_req_t            next_req;
  weight_res_t         head_due;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_error(input string msg);
    $display("weight check: %s at %0t", msg, $time);
    error_count++;
  endtask

  // Table samples around a distance; returns 0 when at or past the radius.
  function automatic bit locate_samples(input logic signed [DIST_W-1:0] dist_in,
                                        output logic [INDEX_W-1:0] lo,
                                        output logic [INDEX_W-1:0] hi,
                                        output logic [FRAC_W-1:0] frac);
    logic [DIST_W-1:0]         mag;
    logic [DIST_W+SCALE_W-1:0] pos;
    logic [DIST_W-1:0]         whole;
    mag   = dist_in[DIST_W-1] ? ~dist_in + 1'b1 : dist_in;   // most negative stays 2^23
    pos   = (DIST_W+SCALE_W)'(mag) * (DIST_W+SCALE_W)'(cur_scale);
    whole = pos[DIST_W+SCALE_W-1:POS_INT_LSB];
    frac  = pos[POS_INT_LSB-1:POS_INT_LSB-FRAC_W];
    lo    = whole[INDEX_W-1:0];
    hi    = (frac != '0) ? lo + 1'b1 : lo;
    return whole < DIST_W'(cur_steps);
  endfunction

  function automatic weight_res_t predict_weight(input logic signed [DIST_W-1:0] dist_in);
    weight_res_t         res;
    logic [INDEX_W-1:0]  lo, hi;
    logic [FRAC_W-1:0]   frac;
    logic [33:0]         blend;
    res.weight = '0;
    res.beyond = 1'b1;
    if (locate_samples(dist_in, lo, hi, frac)) begin
      blend = (34'd65536 - frac) * table_copy[lo] + 34'(frac) * table_copy[hi] + 34'd32768;
      res.weight = blend[31:16];
      res.beyond = 1'b0;
    end
    return res;
  endfunction

  function automatic void load_entry(input logic [INDEX_W-1:0] idx,
                                     input logic [SAMPLE_W-1:0] sample);
    lut_req_t item;
    item.opcode      = gwil_pkg::OP_WRITE;
    item.distance    = DIST_W'($urandom);
    item.entry_index = idx;
    item.entry_value = sample;
    loaded[idx]      = 1'b1;
    pending_reqs.push_back(item);
    queued_count++;
  endfunction

  // Any sample a lookup inside the radius will touch is loaded first, so it reads no unwritten entry.
  function automatic void request_weight(input logic signed [DIST_W-1:0] dist_in);
    lut_req_t           item;
    logic [INDEX_W-1:0] lo, hi;
    logic [FRAC_W-1:0]  frac;
    if (locate_samples(dist_in, lo, hi, frac)) begin
      if (!loaded[lo]) load_entry(lo, SAMPLE_W'($urandom));
      if (!loaded[hi]) load_entry(hi, SAMPLE_W'($urandom));
    end
    item.opcode      = gwil_pkg::OP_EVALUATE;
    item.distance    = dist_in;
    item.entry_index = INDEX_W'($urandom);
    item.entry_value = SAMPLE_W'($urandom);
    pending_reqs.push_back(item);
    queued_count++;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Mostly distances inside or just past the radius; some exact step edges,
  // some fully random bit patterns.
  function automatic logic signed [DIST_W-1:0] pick_distance();
    logic [63:0] span;
    logic [63:0] mag;
    int unsigned k;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return DIST_W'($urandom);
    if (sel == 1 && cur_scale != '0) begin
      k   = $urandom_range(0, 1) ? cur_steps : $urandom_range(0, cur_steps);
      mag = ((64'(k) << 32) + cur_scale - 1) / cur_scale;
      if (mag != 0 && $urandom_range(0, 1) == 1) mag = mag - 1;
    end else begin
      span = (cur_scale == '0) ? MAG_MAX : ((64'(cur_steps) + 2) << 32) / cur_scale;
      if (span > MAG_MAX) span = MAG_MAX;
      mag = $urandom_range(0, int'(span));
    end
    if (mag > MAG_MAX) mag = MAG_MAX;
    return DIST_W'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] which,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_idle();
    int n;
    n = 0;
    while ((pending_reqs.size() != 0 || req_ch.valid || weight_due.size() != 0)
           && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (weight_due.size() != 0) begin
      flag_error($sformatf("%0d weights never arrived", weight_due.size()));
      weight_due.delete();
    end
    // table writes produce no result, so give the pipe time to empty
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_fire) req_gap = stall_on ? $urandom_range(0, 5) : 0;
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= next_req.opcode;
        req_ch.distance    <= next_req.distance;
        req_ch.entry_index <= next_req.entry_index;
        req_ch.entry_value <= next_req.entry_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp_fire) rsp_gap = stall_on ? $urandom_range(0, 5) : 0;
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: register mirror, table mirror, prediction and result check
  always @(posedge clk) begin
    req_fire <= req_ch.valid && req_ch.ready;
    rsp_fire <= rsp_ch.valid && rsp_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    if (rst) begin
      cur_scale = gwil_pkg::INDEX_SCALE_RST;
      cur_steps = gwil_pkg::STEPS_IN_USE_RST;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          gwil_pkg::REG_INDEX_SCALE:  cur_scale = cfg_ch.data;
          gwil_pkg::REG_STEPS_IN_USE: cur_steps = cfg_ch.data[STEPS_W-1:0];
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (weight_due.size() == 0) begin
          flag_error($sformatf("result transfer with nothing pending, weight %h",
                               rsp_ch.weight));
        end else begin
          head_due = weight_due.pop_front();
          if (rsp_ch.weight !== head_due.weight)
            flag_error($sformatf("weight %h, predicted %h", rsp_ch.weight, head_due.weight));
          if (rsp_ch.beyond_radius !== head_due.beyond)
            flag_error($sformatf("beyond_radius %b, predicted %b",
                                 rsp_ch.beyond_radius, head_due.beyond));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.opcode == gwil_pkg::OP_WRITE)
          table_copy[req_ch.entry_index] = req_ch.entry_value;
        else
          weight_due.push_back(predict_weight(req_ch.distance));
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0]    scale_set;
    logic [CFG_DATA_W-1:0] steps_set;
    int                    phase_end;
    rst                = 1'b1;
    stall_on           = 1'b1;
    error_count        = 0;
    queued_count       = 0;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = gwil_pkg::OP_EVALUATE;
    req_ch.distance    = '0;
    req_ch.entry_index = '0;
    req_ch.entry_value = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = gwil_pkg::REG_INDEX_SCALE;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: unit scale, steps 992
    load_entry(INDEX_W'(0), 16'hFFFF);
    load_entry(INDEX_W'(1), 16'h0000);
    load_entry(INDEX_W'(2), 16'h8000);
    load_entry(INDEX_W'(1023), 16'hFFFF);
    request_weight(24'sh000000);           // exactly on a sample
    request_weight(24'sh008000);           // halfway between full and zero
    request_weight(-24'sh008000);
    request_weight(24'sh01FFFF);           // fraction all ones
    request_weight(24'sh000001);
    request_weight(24'sh800000);           // most negative, magnitude 2^23
    request_weight(24'sh7FFFFF);
    wait_for_idle();

    // radius edge
    write_register(gwil_pkg::REG_STEPS_IN_USE, CFG_DATA_W'(4));
    request_weight(24'sh040000);
    request_weight(-24'sh040000);
    request_weight(24'sh03FFFF);           // last step, blends into entry four
    request_weight(24'sh000000);
    wait_for_idle();

    // no steps: everything lies past the radius
    write_register(gwil_pkg::REG_STEPS_IN_USE, CFG_DATA_W'(0));
    request_weight(24'sh000000);
    request_weight(24'sh7FFFFF);
    wait_for_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          scale_set = gwil_pkg::INDEX_SCALE_RST;
          steps_set = CFG_DATA_W'(gwil_pkg::STEPS_IN_USE_RST);
        end
        1: begin scale_set = '1;              steps_set = CFG_DATA_W'(1023); end
        2: begin scale_set = '0;              steps_set = CFG_DATA_W'(1); end
        3: begin scale_set = SCALE_W'(1);     steps_set = CFG_DATA_W'(1023); end
        4: begin scale_set = SCALE_W'(8 << 16); steps_set = CFG_DATA_W'(1023); end
        5: begin
          scale_set = $urandom_range(32'h1000, 32'h80_0000);
          steps_set = $urandom_range(1, 1023);
        end
        6: begin scale_set = $urandom; steps_set = $urandom; end  // upper data bits ignored
        default: begin scale_set = $urandom; steps_set = $urandom_range(1, 1023); end
      endcase
      stall_on = (p == 2 || p == 7) ? 1'b0 : 1'b1;
      if ($urandom_range(0, 1)) begin
        write_register(gwil_pkg::REG_INDEX_SCALE, scale_set);
        write_register(gwil_pkg::REG_STEPS_IN_USE, steps_set);
      end else begin
        write_register(gwil_pkg::REG_STEPS_IN_USE, steps_set);
        write_register(gwil_pkg::REG_INDEX_SCALE, scale_set);
      end
      // table loads that a lookup pulls in count towards the phase budget
      phase_end = queued_count + PHASE_ITEMS;
      while (queued_count < phase_end) begin
        if ($urandom_range(0, 99) < 15)
          load_entry(INDEX_W'($urandom), pick_sample());
        else
          request_weight(pick_distance());
      end
      wait_for_idle();
    end

    if (error_count == 0) begin
      $display("gaussian_weight_interp_lut: match");
    end else begin
      $display("gaussian_weight_interp_lut: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("gaussian_weight_interp_lut: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/gwil_pkg.sv
src/gwil_ifs.sv
src/gwil_ram.sv
src/gaussian_weight_interp_lut.sv
src/gwil_checker.sv
sim/gaussian_weight_interp_lut_test.sv
